@@ design/quadratic_probe_hash_map_macros.svh @@
// assertion macros used by the hash map top level
`ifndef QUADRATIC_PROBE_HASH_MAP_MACROS_SVH
`define QUADRATIC_PROBE_HASH_MAP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define QPHM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define QPHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/qphm_pkg.sv @@
// types and constants of the quadratic probe hash map
package qphm_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int LIMIT_W = 9;
    localparam int COUNT_W = 9;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                    operation;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] found_value;
        logic [COUNT_W-1:0]      entry_count;
    } out_word_t;

    // one table slot as held in memory
    typedef struct packed {
        logic             occupied;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_entry_t;

endpackage

@@ design/qphm_ram.sv @@
// generic single-write, single-read ram with registered read data
module qphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/qphm_hash.sv @@
// home slot unit: key modulo table size, four key bits a cycle for sizes other than a power of two
module qphm_hash #(
    parameter int SLOTS = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [qphm_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [$clog2(SLOTS)-1:0]  slot
);

    import qphm_pkg::*;

    localparam int  SLOT_W = $clog2(SLOTS);
    localparam bit  POW2   = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int  DIGITS = KEY_W / 4;
    localparam int  CNT_W  = $clog2(DIGITS);
    localparam logic [SLOT_W:0] MODULUS = (SLOT_W + 1)'(SLOTS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [KEY_W-1:0]    sh_reg, sh_next;
    logic [SLOT_W-1:0]   rem_reg, rem_next;
    logic [SLOT_W-1:0]   rem_step;

    // four restoring remainder steps on the top key bits
    always_comb
    begin
        logic [SLOT_W:0] tmp;
        rem_step = rem_reg;
        for (int k = 0; k < 4; k++)
        begin
            tmp = {rem_step, sh_reg[KEY_W-1-k]};
            if (tmp >= MODULUS)
            begin
                tmp = tmp - MODULUS;
            end
            rem_step = tmp[SLOT_W-1:0];
        end
    end

    // sequencing of the remainder walk
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            if (POW2)
            begin
                rem_next  = key[SLOT_W-1:0];
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = '0;
                sh_next   = key;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            sh_next  = sh_reg << 4;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign slot = rem_reg;

endmodule

@@ design/quadratic_probe_hash_map.sv @@
// quadratic probe hash map: top level with probe sequencer
// after reset the table memory is cleared, one slot a cycle, and no word is taken meanwhile.
// home slot comes from the low key bits (power-of-two size) or from the remainder unit (other sizes).
// each probe passes through the single table memory: read, then compare.
// the result is loaded into the output register once the probes end, or with no probe at
// probe limit zero; a new word can be taken in the cycle after the result is loaded.
module quadratic_probe_hash_map #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  qphm_pkg::in_word_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output qphm_pkg::out_word_t           out_data,
    input  logic                          cfg_we,
    input  logic [qphm_pkg::LIMIT_W-1:0]  cfg_wdata
);

    import qphm_pkg::*;

    `include "quadratic_probe_hash_map_macros.svh"

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int ENTRY_W = $bits(slot_entry_t);
    localparam logic [SLOT_W:0]   MODULUS   = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    state_t                  state_reg, state_next;
    logic [SLOT_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [LIMIT_W-1:0]      limit_reg, limit_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [LIMIT_W-1:0]      probe_reg, probe_next;
    logic                    op_reg, op_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [SLOT_W-1:0]       step_reg, step_next;
    status_t                 res_status_reg, res_status_next;
    logic signed [VAL_W-1:0] res_value_reg, res_value_next;
    logic                    out_valid_reg, out_valid_next;
    out_word_t               out_data_reg, out_data_next;

    logic                    accept;
    logic                    hash_start;
    logic                    hash_done;
    logic [SLOT_W-1:0]       hash_slot;
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_waddr;
    slot_entry_t             mem_wdata;
    slot_entry_t             mem_rdata;
    logic [ENTRY_W-1:0]      mem_rbits;
    logic                    hit_empty;
    logic                    hit_key;
    logic                    last_probe;
    logic                    out_load;
    logic [SLOT_W:0]         idx_sum;
    logic [SLOT_W:0]         step_sum;
    status_t                 miss_status;

    assign mem_rdata  = slot_entry_t'(mem_rbits);
    assign accept     = in_valid && in_ready;
    assign hit_empty  = !mem_rdata.occupied;
    assign hit_key    = mem_rdata.key == key_reg;
    assign last_probe = ({1'b0, probe_reg} + 1'b1) == {1'b0, limit_reg};
    assign out_load   = !out_valid_reg || out_ready;
    assign miss_status = (op_reg == OP_LOOKUP) ? STAT_NOT_FOUND : STAT_FULL;

    // next slot and next odd step, both reduced modulo the table size
    always_comb
    begin
        idx_sum = {1'b0, idx_reg} + {1'b0, step_reg};
        if (idx_sum >= MODULUS)
        begin
            idx_sum = idx_sum - MODULUS;
        end
        step_sum = {1'b0, step_reg} + (SLOT_W + 1)'(2);
        if (step_sum >= MODULUS)
        begin
            step_sum = step_sum - MODULUS;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (limit_reg == '0) ? S_RESP : S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hit_empty || hit_key || last_probe)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: handshake, memory write, hash start
    always_comb
    begin
        in_ready   = 1'b0;
        hash_start = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = '{occupied: 1'b1, key: key_reg, value: val_reg};
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                hash_start = in_valid && (limit_reg != '0);
            end
            S_CHECK:
            begin
                mem_we = hit_empty && (op_reg == OP_INSERT);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        probe_next      = probe_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (cfg_we)
        begin
            limit_next = cfg_wdata;
        end

        // clear sweep
        if (state_reg == S_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        // take the input word
        if (accept)
        begin
            op_next         = in_data.operation;
            key_next        = in_data.key;
            val_next        = in_data.value;
            probe_next      = '0;
            step_next       = SLOT_W'(1);
            res_value_next  = '0;
            res_status_next = (in_data.operation == OP_LOOKUP) ? STAT_NOT_FOUND : STAT_FULL;
        end

        if (state_reg == S_HASH && hash_done)
        begin
            idx_next = hash_slot;
        end

        // compare the slot read back
        if (state_reg == S_CHECK)
        begin
            if (hit_empty)
            begin
                if (op_reg == OP_INSERT)
                begin
                    count_next      = count_reg + 1'b1;
                    res_status_next = STAT_INSERTED;
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
            end
            else if (hit_key)
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    res_status_next = STAT_FOUND;
                    res_value_next  = mem_rdata.value;
                end
                else
                begin
                    res_status_next = STAT_DUPLICATE;
                end
            end
            else
            begin
                res_status_next = miss_status;
                probe_next      = probe_reg + 1'b1;
                idx_next        = idx_sum[SLOT_W-1:0];
                step_next       = step_sum[SLOT_W-1:0];
            end
        end

        // output register
        if (state_reg == S_RESP && out_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next.status      = res_status_reg;
            out_data_next.found_value = res_value_reg;
            out_data_next.entry_count = count_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        probe_reg      <= probe_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_data_reg   <= out_data_next;
    end

    // home slot unit
    qphm_hash #(
        .SLOTS (TABLE_SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (in_data.key),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    // table memory: occupied mark, key and value per slot
    qphm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (mem_rbits)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks on the sequencer
    `QPHM_ASSERT_NOW(a_write_only_clear_or_insert, mem_we,
        (state_reg == S_CLEAR) || (state_reg == S_CHECK && op_reg == OP_INSERT && hit_empty),
        "table written outside clear or insert")
    `QPHM_ASSERT_NEXT(a_count_only_on_insert, !(state_reg == S_CHECK && mem_we),
        count_reg == $past(count_reg), "entry count moved without an insert")
    `QPHM_ASSERT_NOW(a_slot_in_range, state_reg == S_READ || state_reg == S_CHECK,
        idx_reg <= LAST_SLOT, "probe slot beyond table")
    `QPHM_ASSERT_NOW(a_found_is_lookup, state_reg == S_RESP && res_status_reg == STAT_FOUND,
        op_reg == OP_LOOKUP, "found reported for an insert")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for the quadratic probe hash map: directed table, random phases, scoreboard
module tb_top;
    import qphm_pkg::*;

    localparam int SLOTS          = 256;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int N_ROWS         = 23;
    localparam int N_PHASES       = 8;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_word_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_word_t           out_data;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;

    // one row of the directed table; expectation used only when typed is set
    typedef struct packed {
        logic [LIMIT_W-1:0]      lim;
        logic                    op;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] val;
        logic                    typed;
        status_t                 st;
        logic signed [VAL_W-1:0] fv;
        logic [COUNT_W-1:0]      cnt;
    } dir_row_t;

    dir_row_t dir_rows [N_ROWS] = '{
        // empty table after reset, key extremes, duplicate refused
        '{9'd256, OP_LOOKUP, 32'h0000_0000, 32'sh0000_0000, 1'b1, STAT_NOT_FOUND,
          32'sh0000_0000, 9'd0},
        '{9'd256, OP_INSERT, 32'h0000_0000, 32'sh7FFF_FFFF, 1'b1, STAT_INSERTED,
          32'sh0000_0000, 9'd1},
        '{9'd256, OP_INSERT, 32'h0000_0000, 32'sh0000_0005, 1'b1, STAT_DUPLICATE,
          32'sh0000_0000, 9'd1},
        '{9'd256, OP_LOOKUP, 32'h0000_0000, 32'sh0000_0000, 1'b1, STAT_FOUND,
          32'sh7FFF_FFFF, 9'd1},
        '{9'd256, OP_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000, 1'b1, STAT_INSERTED,
          32'sh0000_0000, 9'd2},
        '{9'd256, OP_LOOKUP, 32'hFFFF_FFFF, 32'sh0000_0000, 1'b1, STAT_FOUND,
          32'sh8000_0000, 9'd2},
        // collisions on home slot zero and on the top slot, wrap around
        '{9'd256, OP_INSERT, 32'h0000_0100, 32'shFFFF_FFFF, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd256, OP_INSERT, 32'h0000_0200, 32'sh0000_007B, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd256, OP_LOOKUP, 32'h0000_0200, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd256, OP_LOOKUP, 32'h0000_0300, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd256, OP_INSERT, 32'h0000_00FF, 32'sh1234_5678, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd256, OP_LOOKUP, 32'hAAAA_AAAA, 32'sh5555_5555, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd256, OP_INSERT, 32'h5555_5555, 32'shAAAA_AAAA, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd256, OP_LOOKUP, 32'h5555_5555, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd256, OP_INSERT, 32'hFFFF_FFFF, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0},
        // probe limit zero: nothing visited
        '{9'd0,   OP_INSERT, 32'h0000_0007, 32'sh0000_0001, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd0,   OP_LOOKUP, 32'h0000_0000, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0},
        // probe limit one: limit reached on insert and on lookup
        '{9'd1,   OP_INSERT, 32'h0000_0300, 32'sh0000_0009, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd1,   OP_LOOKUP, 32'h0000_0200, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd1,   OP_LOOKUP, 32'h0000_0000, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0},
        // probe limit above the table size
        '{9'd511, OP_LOOKUP, 32'h0000_0400, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0},
        '{9'd511, OP_INSERT, 32'h0000_0400, -32'sd2,         1'b0, STAT_INSERTED, '0, '0},
        '{9'd511, OP_LOOKUP, 32'h0000_0400, 32'sh0000_0000, 1'b0, STAT_INSERTED, '0, '0}
    };

    // random phases: probe limit and number of words each
    int unsigned phase_limit [N_PHASES] = '{256, 511, 8, 1, 0, 3, 511, 256};
    int unsigned phase_words [N_PHASES] = '{300, 150, 400, 150, 60, 250, 80, 80};

    // predictor state
    bit                 slot_used [SLOTS];
    logic [KEY_W-1:0]   slot_keys [SLOTS];
    logic [VAL_W-1:0]   slot_vals [SLOTS];
    int unsigned        stored_count;
    logic [LIMIT_W-1:0] limit_now;

    out_word_t          pending_results [$];
    logic [KEY_W-1:0]   key_pool [$];
    int unsigned        mismatch_count;
    int unsigned        burst_left;
    bit                 gapless;
    bit                 hold_req;

    quadratic_probe_hash_map #(
        .TABLE_SLOTS (SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // walk the quadratic probe sequence and update the table copy
    function automatic out_word_t probe_table(input in_word_t w);
        out_word_t    r;
        int unsigned  i;
        int unsigned  idx;
        r.status      = (w.operation == OP_LOOKUP) ? STAT_NOT_FOUND : STAT_FULL;
        r.found_value = '0;
        for (i = 0; i < limit_now; i++) begin
            idx = int'(({32'd0, w.key} + longint'(i) * longint'(i)) % SLOTS);
            if (!slot_used[idx]) begin
                if (w.operation == OP_INSERT) begin
                    slot_used[idx] = 1'b1;
                    slot_keys[idx] = w.key;
                    slot_vals[idx] = w.value;
                    stored_count++;
                    r.status = STAT_INSERTED;
                end
                else begin
                    r.status = STAT_NOT_FOUND;
                end
                break;
            end
            if (slot_keys[idx] == w.key) begin
                if (w.operation == OP_LOOKUP) begin
                    r.status      = STAT_FOUND;
                    r.found_value = slot_vals[idx];
                end
                else begin
                    r.status = STAT_DUPLICATE;
                end
                break;
            end
        end
        r.entry_count = stored_count[COUNT_W-1:0];
        return r;
    endfunction

    // random word: reused keys, clustered homes, or fully random keys
    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned pick;
        pick        = $urandom_range(0, 9);
        w.operation = ($urandom_range(0, 1) == 1) ? OP_LOOKUP : OP_INSERT;
        if (pick < 4 && key_pool.size() > 0)
            w.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (pick < 7)
            w.key = ($urandom_range(0, 63) << 8) | $urandom_range(0, 31);
        else
            w.key = $urandom;
        w.value = $urandom;
        return w;
    endfunction

    // offer one word in bursts, wait for it to be taken, record its result
    task automatic send_word(input in_word_t w, input bit use_typed, input out_word_t typed);
        int unsigned gap;
        out_word_t   predicted;
        if (burst_left == 0) begin
            gapless = ($urandom_range(0, 3) == 0);
            gap     = gapless ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        predicted = probe_table(w);
        pending_results.push_back(use_typed ? typed : predicted);
        if (w.operation == OP_INSERT) begin
            key_pool.push_back(w.key);
            if (key_pool.size() > 300)
                void'(key_pool.pop_front());
        end
    endtask

    // write the probe limit once every result is back
    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_now = v;
    endtask

    // scoreboard on accepted result words
    always @(posedge clk) begin
        out_word_t want;
        if (out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected: status=%0d value=%0d count=%0d",
                         $time, out_data.status, out_data.found_value, out_data.entry_count);
                mismatch_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_data.status);
                    mismatch_count++;
                end
                if (out_data.found_value !== want.found_value) begin
                    $display("%0t: found_value expected %0d actual %0d",
                             $time, want.found_value, out_data.found_value);
                    mismatch_count++;
                end
                if (out_data.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, out_data.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: segments of steady, random and sparse ready, plus a long hold-off on request
    initial begin : receiver
        int unsigned seg_left;
        int unsigned mode;
        seg_left = 0;
        mode     = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 300);
            end
            seg_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 1);
                2:       out_ready <= ($urandom_range(0, 4) != 0);
                default: out_ready <= (seg_left % 5 == 0);
            endcase
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin : watchdog
        int unsigned stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("FAIL quadratic_probe_hash_map");
        $finish;
    end

    // reset, directed table, random phases, drain
    initial begin : stimulus
        int unsigned n;
        int unsigned ph;
        in_word_t    w;
        out_word_t   typed;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        hold_req       = 1'b0;
        burst_left     = 0;
        gapless        = 1'b0;
        mismatch_count = 0;
        stored_count   = 0;
        limit_now      = LIMIT_RESET;
        for (n = 0; n < SLOTS; n++) begin
            slot_used[n] = 1'b0;
            slot_keys[n] = '0;
            slot_vals[n] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (n = 0; n < N_ROWS; n++) begin
            if (dir_rows[n].lim != limit_now)
                set_limit(dir_rows[n].lim);
            w.operation         = dir_rows[n].op;
            w.key               = dir_rows[n].key;
            w.value             = dir_rows[n].val;
            typed.status        = dir_rows[n].st;
            typed.found_value   = dir_rows[n].fv;
            typed.entry_count   = dir_rows[n].cnt;
            send_word(w, dir_rows[n].typed, typed);
        end

        // random phases over the probe limit settings
        for (ph = 0; ph < N_PHASES; ph++) begin
            set_limit(phase_limit[ph][LIMIT_W-1:0]);
            for (n = 0; n < phase_words[ph]; n++) begin
                if (ph == 0 && n == 60)
                    hold_req = 1'b1;
                send_word(random_word(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS quadratic_probe_hash_map");
        else
            $display("FAIL quadratic_probe_hash_map");
        $finish;
    end

endmodule

@@ quadratic_probe_hash_map.f @@
+incdir+design
design/qphm_pkg.sv
design/qphm_ram.sv
design/qphm_hash.sv
design/quadratic_probe_hash_map.sv
tb/sv/tb_top.sv
